// File: src/osm_pkg.sv
// Shared types and codes for the order-statistic multiset unit.
// No dependencies; used by osm_cell, osm_array and order_statistic_multiset_unit.
package osm_pkg;

    localparam int unsigned DataWidth   = 32;
    localparam int unsigned CmdWidth    = 3;
    localparam int unsigned StatusWidth = 2;

    typedef enum logic [CmdWidth-1:0] {
        CMD_INSERT = 3'd0,
        CMD_ERASE  = 3'd1,
        CMD_RANK   = 3'd2,
        CMD_KTH    = 3'd3,
        CMD_PRED   = 3'd4,
        CMD_SUCC   = 3'd5
    } t_cmd;

    localparam logic [StatusWidth-1:0] StOk       = 2'd0;
    localparam logic [StatusWidth-1:0] StNotFound = 2'd1;
    localparam logic [StatusWidth-1:0] StFull     = 2'd2;

    // What every slot does at the next edge.
    typedef enum logic [1:0] {
        SH_HOLD   = 2'd0,
        SH_INSERT = 2'd1,
        SH_ERASE  = 2'd2
    } t_shift;

    typedef struct packed {
        logic [CmdWidth-1:0]         command;
        logic signed [DataWidth-1:0] operand;
    } t_osm_req;

    typedef struct packed {
        logic signed [DataWidth-1:0] answer;
        logic [StatusWidth-1:0]      status;
    } t_osm_rsp;

endpackage

// File: src/order_statistic_multiset_unit.sv
// Top level of the order-statistic multiset: stream ports, request register
// and result register around osm_array. Depends on osm_pkg and osm_array.
//
//  Channel   Direction  Payload (tdata, lowest bit first)
//  s_axis    in         command[2:0], operand_value[34:3], zero pad[39:35]
//  m_axis    out        answer[31:0], status[33:32], zero pad[39:34]
//
// A request is taken in every cycle while the result stage advances. The request
// register holds it while the slot row compares all stored values at once; when it
// fires, the store shifts on insert or erase and the result register loads, now valid.
// Back-to-back requests therefore see the store as the previous request left it.
// While a result waits untaken the request register holds, and s_axis_tready falls once
// that register is occupied too. Reset is synchronous, active low, and empties everything.
module order_statistic_multiset_unit #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // command[2:0], operand_value[34:3]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // answer[31:0], status[33:32]
);

    localparam int unsigned ReqBits = osm_pkg::CmdWidth + osm_pkg::DataWidth;
    localparam int unsigned RspBits = osm_pkg::DataWidth + osm_pkg::StatusWidth;

    logic              r_req_vld;
    osm_pkg::t_osm_req r_req;
    logic              r_rsp_vld;
    osm_pkg::t_osm_rsp r_rsp;
    osm_pkg::t_osm_rsp rsp;

    logic advance;
    logic fire;

    // The result stage moves whenever its register is free or is being taken.
    assign advance       = !r_rsp_vld || m_axis_tready;
    assign fire          = r_req_vld && advance;
    assign s_axis_tready = !r_req_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_req_vld <= s_axis_tvalid;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_req.command <= s_axis_tdata[osm_pkg::CmdWidth-1:0];
            r_req.operand <= $signed(s_axis_tdata[ReqBits-1:osm_pkg::CmdWidth]);
        end
    end

    osm_array #(
        .CAPACITY (CAPACITY)
    ) u_array (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_req   (r_req),
        .o_rsp   (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_vld <= 1'b0;
        end else if (advance) begin
            r_rsp_vld <= r_req_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_rsp <= rsp;
        end
    end

    assign m_axis_tvalid = r_rsp_vld;
    assign m_axis_tdata  = {{(40 - RspBits){1'b0}}, r_rsp.status, r_rsp.answer};

endmodule

// File: src/osm_cell.sv
// One slot of the sorted store: holds a value, compares it with the operand
// and shifts left or right on erase or insert. Depends on osm_pkg.
module osm_cell (
    input  logic                                 i_clk,
    input  logic                                 i_occupied,
    input  osm_pkg::t_shift                      i_shift,
    input  logic signed [osm_pkg::DataWidth-1:0] i_operand,
    input  logic signed [osm_pkg::DataWidth-1:0] i_left_value,
    input  logic signed [osm_pkg::DataWidth-1:0] i_right_value,
    input  logic                                 i_left_le,
    output logic signed [osm_pkg::DataWidth-1:0] o_value,
    output logic                                 o_lt,
    output logic                                 o_le,
    output logic                                 o_eq
);

    logic signed [osm_pkg::DataWidth-1:0] r_value;
    logic signed [osm_pkg::DataWidth-1:0] n_value;

    assign o_value = r_value;
    assign o_lt    = i_occupied && (r_value <  i_operand);
    assign o_le    = i_occupied && (r_value <= i_operand);
    assign o_eq    = i_occupied && (r_value == i_operand);

    // Insert goes after any equal copies; erase pulls the right neighbour in
    // from the first slot that is not below the operand.
    always_comb begin
        n_value = r_value;
        unique case (i_shift)
            osm_pkg::SH_INSERT: begin
                if (!o_le) begin
                    n_value = i_left_le ? i_operand : i_left_value;
                end
            end
            osm_pkg::SH_ERASE: begin
                if (!o_lt) begin
                    n_value = i_right_value;
                end
            end
            default: n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

// File: src/osm_array.sv
// Row of slots with the element count, the one-hot selection of answers and
// the command decode. Depends on osm_pkg and osm_cell.
module osm_array #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  osm_pkg::t_osm_req i_req,
    output osm_pkg::t_osm_rsp o_rsp
);

    localparam int unsigned CntWidth = $clog2(CAPACITY + 1);
    localparam int unsigned DW       = osm_pkg::DataWidth;

    logic [CntWidth-1:0] r_count;
    logic [CntWidth-1:0] n_count;

    logic signed [DW-1:0] cell_val [CAPACITY];
    logic [CAPACITY-1:0]  occ;
    logic [CAPACITY-1:0]  lt;
    logic [CAPACITY-1:0]  le;
    logic [CAPACITY-1:0]  eq;
    logic [CAPACITY-1:0]  left_le;
    logic [CAPACITY-1:0]  pred_sel;
    logic [CAPACITY-1:0]  succ_sel;
    logic [CAPACITY-1:0]  kth_sel;

    osm_pkg::t_shift n_shift;
    osm_pkg::t_shift shift;

    logic signed [DW-1:0] pred_val;
    logic signed [DW-1:0] succ_val;
    logic signed [DW-1:0] kth_val;
    logic [CntWidth-1:0]  below_cnt;
    logic                 k_ok;

    assign shift = i_fire ? n_shift : osm_pkg::SH_HOLD;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
        logic signed [DW-1:0] right_value;

        assign occ[i] = r_count > CntWidth'(i);

        if (i == 0) begin : g_first
            assign left_le[i] = 1'b1;
        end else begin : g_inner
            assign left_le[i] = le[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_value = cell_val[i];
            assign pred_sel[i] = lt[i];
        end else begin : g_body
            assign right_value = cell_val[i+1];
            assign pred_sel[i] = lt[i] && !lt[i+1];
        end

        assign succ_sel[i] = occ[i] && !le[i] && left_le[i];
        assign kth_sel[i]  = i_req.operand == DW'(i + 1);

        osm_cell u_cell (
            .i_clk         (i_clk),
            .i_occupied    (occ[i]),
            .i_shift       (shift),
            .i_operand     (i_req.operand),
            .i_left_value  ((i == 0) ? cell_val[i] : cell_val[(i == 0) ? 0 : i-1]),
            .i_right_value (right_value),
            .i_left_le     (left_le[i]),
            .o_value       (cell_val[i]),
            .o_lt          (lt[i]),
            .o_le          (le[i]),
            .o_eq          (eq[i])
        );
    end

    // Every selection vector is one-hot or empty, so OR trees gather the answers.
    always_comb begin
        pred_val  = '0;
        succ_val  = '0;
        kth_val   = '0;
        below_cnt = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            pred_val  = pred_val  | (pred_sel[i] ? cell_val[i] : '0);
            succ_val  = succ_val  | (succ_sel[i] ? cell_val[i] : '0);
            kth_val   = kth_val   | (kth_sel[i]  ? cell_val[i] : '0);
            below_cnt = below_cnt | (pred_sel[i] ? CntWidth'(i + 1) : '0);
        end
    end

    assign k_ok = !i_req.operand[DW-1] && (i_req.operand != '0)
               && ($unsigned(i_req.operand) <= DW'(r_count));

    always_comb begin
        o_rsp.answer = '0;
        o_rsp.status = osm_pkg::StOk;
        n_shift      = osm_pkg::SH_HOLD;
        n_count      = r_count;
        unique case (osm_pkg::t_cmd'(i_req.command))
            osm_pkg::CMD_INSERT: begin
                if (r_count == CntWidth'(CAPACITY)) begin
                    o_rsp.status = osm_pkg::StFull;
                end else begin
                    n_shift = osm_pkg::SH_INSERT;
                    n_count = r_count + CntWidth'(1);
                end
            end
            osm_pkg::CMD_ERASE: begin
                if (|eq) begin
                    n_shift = osm_pkg::SH_ERASE;
                    n_count = r_count - CntWidth'(1);
                end else begin
                    o_rsp.status = osm_pkg::StNotFound;
                end
            end
            osm_pkg::CMD_RANK: begin
                o_rsp.answer = DW'(below_cnt) + DW'(1);
            end
            osm_pkg::CMD_KTH: begin
                if (k_ok) begin
                    o_rsp.answer = kth_val;
                end else begin
                    o_rsp.status = osm_pkg::StNotFound;
                end
            end
            osm_pkg::CMD_PRED: begin
                if (|lt) begin
                    o_rsp.answer = pred_val;
                end else begin
                    o_rsp.status = osm_pkg::StNotFound;
                end
            end
            osm_pkg::CMD_SUCC: begin
                if (|succ_sel) begin
                    o_rsp.answer = succ_val;
                end else begin
                    o_rsp.status = osm_pkg::StNotFound;
                end
            end
            default: o_rsp.status = osm_pkg::StNotFound;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_fire) begin
            r_count <= n_count;
        end
    end

endmodule

// File: tb/testbench.sv
// Self-checking testbench for order_statistic_multiset_unit: drives commands on s_axis,
// predicts every answer with its own sorted multiset and checks each result on m_axis.
// Depends on osm_pkg and on the RTL of the unit.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          ClkPeriod      = 10;
    localparam int          Capacity       = 64;
    localparam int          CycleLimit     = 500_000;
    localparam int          LongHoldCycles = 300;
    localparam int          SettleCycles   = 10;

    localparam logic signed [osm_pkg::DataWidth-1:0] MinValue = 32'sh8000_0000;
    localparam logic signed [osm_pkg::DataWidth-1:0] MaxValue = 32'sh7FFF_FFFF;

    // Command codes outside the defined set; the unit must answer them as not found.
    localparam logic [osm_pkg::CmdWidth-1:0] CmdSpare6 = 3'd6;
    localparam logic [osm_pkg::CmdWidth-1:0] CmdSpare7 = 3'd7;

    // One accepted request together with the answer it must produce.
    typedef struct packed {
        logic [osm_pkg::CmdWidth-1:0]         command;
        logic signed [osm_pkg::DataWidth-1:0] operand;
        osm_pkg::t_osm_rsp                    result;
    } t_pending_answer;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;   // command[2:0], operand_value[34:3]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;         // answer[31:0], status[33:32]

    // Predicted contents of the store, kept in ascending order.
    logic signed [osm_pkg::DataWidth-1:0] multiset_q[$];
    t_pending_answer                      pending_answers_q[$];

    bit src_idle_en       = 1'b1;
    bit sink_idle_en      = 1'b1;
    int sink_hold_cycles  = 0;

    int error_count       = 0;
    int results_checked   = 0;
    int cycle_count       = 0;
    int peak_size         = 0;
    int full_rejections   = 0;
    int not_found_answers = 0;
    int requests_by_cmd[8];

    order_statistic_multiset_unit #(
        .CAPACITY(Capacity)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(ClkPeriod / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Works out the answer to one request and applies it to the predicted store.
    // Inserts go after any equal copies; erase removes the lowest copy. Rank is one more
    // than the count of elements strictly below the operand, whether or not it is stored.
    function automatic osm_pkg::t_osm_rsp predict_answer(
        input logic [osm_pkg::CmdWidth-1:0]         cmd,
        input logic signed [osm_pkg::DataWidth-1:0] operand);
        osm_pkg::t_osm_rsp rsp;
        int                below;
        int                not_above;
        int                n;
        rsp.answer = '0;
        rsp.status = osm_pkg::StOk;
        n          = multiset_q.size();
        below      = 0;
        not_above  = 0;
        foreach (multiset_q[i]) begin
            if (multiset_q[i] < operand) below++;
            if (multiset_q[i] <= operand) not_above++;
        end
        case (cmd)
            osm_pkg::CMD_INSERT: begin
                if (n >= Capacity) begin
                    rsp.status = osm_pkg::StFull;
                end else begin
                    multiset_q.insert(not_above, operand);
                end
            end
            osm_pkg::CMD_ERASE: begin
                if (below >= n || multiset_q[below] != operand) begin
                    rsp.status = osm_pkg::StNotFound;
                end else begin
                    multiset_q.delete(below);
                end
            end
            osm_pkg::CMD_RANK: begin
                rsp.answer = below + 1;
            end
            osm_pkg::CMD_KTH: begin
                // k is one-based; zero and negative k are out of range.
                if (operand <= 0 || operand > n) begin
                    rsp.status = osm_pkg::StNotFound;
                end else begin
                    rsp.answer = multiset_q[operand - 1];
                end
            end
            osm_pkg::CMD_PRED: begin
                if (below == 0) begin
                    rsp.status = osm_pkg::StNotFound;
                end else begin
                    rsp.answer = multiset_q[below - 1];
                end
            end
            osm_pkg::CMD_SUCC: begin
                if (not_above >= n) begin
                    rsp.status = osm_pkg::StNotFound;
                end else begin
                    rsp.answer = multiset_q[not_above];
                end
            end
            default: begin
                rsp.status = osm_pkg::StNotFound;
            end
        endcase
        if (multiset_q.size() > peak_size) peak_size = multiset_q.size();
        if (rsp.status == osm_pkg::StFull) full_rejections++;
        if (rsp.status == osm_pkg::StNotFound) not_found_answers++;
        return rsp;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offers one request after a random gap when idling is enabled and waits for it to be
    // taken. On acceptance the expected answer is queued. The valid stays high afterwards,
    // so a following request with no gap goes out in the very next cycle.
    task automatic send_request(input logic [osm_pkg::CmdWidth-1:0]         cmd,
                                input logic signed [osm_pkg::DataWidth-1:0] operand);
        int unsigned     gap;
        t_pending_answer entry;
        gap = src_idle_en ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, operand, cmd};
        do @(posedge i_clk); while (!s_axis_tready);
        entry.command = cmd;
        entry.operand = operand;
        entry.result  = predict_answer(cmd, operand);
        pending_answers_q.push_back(entry);
        requests_by_cmd[cmd]++;
    endtask

    // Stops offering requests and waits until every queued answer has come back.
    task automatic wait_until_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_answers_q.size() != 0) @(posedge i_clk);
    endtask

    // Operand mix: stored values and their neighbours, so that erase, predecessor
    // and successor hit real elements and duplicates build up, plus small values,
    // the extremes of the signed range and fully random words.
    function automatic logic signed [osm_pkg::DataWidth-1:0] pick_value();
        int unsigned                          sel;
        int                                   n;
        logic signed [osm_pkg::DataWidth-1:0] v;
        n   = multiset_q.size();
        sel = $urandom_range(0, 5);
        if (n == 0 && (sel == 2 || sel == 3)) sel = 0;
        case (sel)
            0: v = $urandom;
            1: v = int'($urandom_range(0, 8)) - 4;
            2: v = multiset_q[$urandom_range(0, n - 1)];
            3: v = multiset_q[$urandom_range(0, n - 1)] + ($urandom_range(0, 1) ? 1 : -1);
            4: begin
                case ($urandom_range(0, 3))
                    0:       v = MinValue;
                    1:       v = MaxValue;
                    2:       v = 0;
                    default: v = -1;
                endcase
            end
            default: v = int'($urandom_range(0, 1000)) - 500;
        endcase
        return v;
    endfunction

    // k for the k-th smallest command: mostly in range, otherwise zero, one past
    // the end, negative or a random word.
    function automatic logic signed [osm_pkg::DataWidth-1:0] pick_rank_index();
        int unsigned                          sel;
        int                                   n;
        logic signed [osm_pkg::DataWidth-1:0] k;
        n   = multiset_q.size();
        sel = $urandom_range(0, 9);
        if (sel < 7 && n > 0) begin
            k = $urandom_range(1, n);
        end else begin
            case (sel % 4)
                0:       k = 0;
                1:       k = n + 1;
                2:       k = -int'($urandom_range(1, 1000));
                default: k = $urandom;
            endcase
        end
        return k;
    endfunction

    // One random request. Inserts are weighted so that the store drifts between
    // nearly empty and full; erase mostly names an element that is present.
    task automatic send_random_request();
        int unsigned r;
        int unsigned insert_weight;
        int          n;
        n             = multiset_q.size();
        insert_weight = (n > 48) ? 22 : 34;
        r             = $urandom_range(0, 99);
        if (r < insert_weight) begin
            send_request(osm_pkg::CMD_INSERT, pick_value());
        end else if (r < insert_weight + 26) begin
            if (n > 0 && $urandom_range(0, 9) < 7) begin
                send_request(osm_pkg::CMD_ERASE, multiset_q[$urandom_range(0, n - 1)]);
            end else begin
                send_request(osm_pkg::CMD_ERASE, pick_value());
            end
        end else if (r < insert_weight + 36) begin
            send_request(osm_pkg::CMD_RANK, pick_value());
        end else if (r < insert_weight + 50) begin
            send_request(osm_pkg::CMD_KTH, pick_rank_index());
        end else if (r < insert_weight + 58) begin
            send_request(osm_pkg::CMD_PRED, pick_value());
        end else begin
            send_request(osm_pkg::CMD_SUCC, pick_value());
        end
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // The receiver holds ready low for a random, possibly empty stall before each result
    // while idling is enabled. When a long hold is asked for, it keeps ready low throughout
    // the hold so that the result register fills and the unit stops taking requests.
    initial begin : result_sink
        int unsigned stall;
        wait (i_rst_n === 1'b1);
        forever begin
            if (sink_hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                repeat (sink_hold_cycles) @(posedge i_clk);
                sink_hold_cycles = 0;
                m_axis_tready <= 1'b1;
            end else begin
                stall = sink_idle_en ? $urandom_range(0, 10) : 0;
                if (stall > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
                m_axis_tready <= 1'b1;
            end
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what);
        error_count++;
        $display("%0t ns: %s", $time, what);
    endtask

    // Every result taken on m_axis is compared with the oldest queued answer.
    always @(posedge i_clk) begin : answer_checker
        t_pending_answer                      head;
        logic signed [osm_pkg::DataWidth-1:0] got_answer;
        logic [osm_pkg::StatusWidth-1:0]      got_status;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_answer = m_axis_tdata[31:0];
            got_status = m_axis_tdata[33:32];
            if (pending_answers_q.size() == 0) begin
                report_mismatch($sformatf(
                    "result with nothing outstanding: answer %0d status %0d",
                    got_answer, got_status));
            end else begin
                head = pending_answers_q.pop_front();
                results_checked++;
                if (got_answer !== head.result.answer) begin
                    report_mismatch($sformatf(
                        "command %0d operand %0d: answer %0d, predicted %0d",
                        head.command, head.operand, got_answer, head.result.answer));
                end
                if (got_status !== head.result.status) begin
                    report_mismatch($sformatf(
                        "command %0d operand %0d: status %0d, predicted %0d",
                        head.command, head.operand, got_status, head.result.status));
                end
            end
        end
    end

    // Guards against a unit that stops answering.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("Run stopped after %0d cycles with %0d answers outstanding.",
                     cycle_count, pending_answers_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Queries on the empty store, the extremes of the signed range, duplicates,
    // rank of an absent value, k out of range in every direction, missing
    // predecessor and successor, erase of an absent value and the spare codes.
    task automatic test_directed_cases();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        send_request(osm_pkg::CMD_RANK, 5);
        send_request(osm_pkg::CMD_KTH, 1);
        send_request(osm_pkg::CMD_PRED, 0);
        send_request(osm_pkg::CMD_SUCC, 0);
        send_request(osm_pkg::CMD_ERASE, 7);
        send_request(osm_pkg::CMD_INSERT, MinValue);
        send_request(osm_pkg::CMD_INSERT, MaxValue);
        send_request(osm_pkg::CMD_INSERT, 0);
        send_request(osm_pkg::CMD_INSERT, 0);
        send_request(osm_pkg::CMD_INSERT, -1);
        send_request(osm_pkg::CMD_PRED, MinValue);
        send_request(osm_pkg::CMD_SUCC, MaxValue);
        send_request(osm_pkg::CMD_PRED, 0);
        send_request(osm_pkg::CMD_SUCC, 0);
        send_request(osm_pkg::CMD_SUCC, -1);
        send_request(osm_pkg::CMD_RANK, 0);
        send_request(osm_pkg::CMD_RANK, 5);
        send_request(osm_pkg::CMD_RANK, MinValue);
        send_request(osm_pkg::CMD_KTH, 0);
        send_request(osm_pkg::CMD_KTH, MinValue);
        send_request(osm_pkg::CMD_KTH, MaxValue);
        send_request(osm_pkg::CMD_KTH, 6);
        send_request(osm_pkg::CMD_KTH, 5);
        send_request(osm_pkg::CMD_KTH, 3);
        send_request(osm_pkg::CMD_ERASE, 0);
        send_request(osm_pkg::CMD_ERASE, 0);
        send_request(osm_pkg::CMD_ERASE, 0);
        send_request(CmdSpare6, 1);
        send_request(CmdSpare7, MaxValue);
        wait_until_drained();
    endtask

    // Fills the store to capacity, tries to insert beyond it, queries the full
    // store at its edges and then erases most of it again.
    task automatic test_fill_to_capacity();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        while (multiset_q.size() < Capacity) send_request(osm_pkg::CMD_INSERT, pick_value());
        send_request(osm_pkg::CMD_INSERT, pick_value());
        send_request(osm_pkg::CMD_INSERT, MaxValue);
        send_request(osm_pkg::CMD_INSERT, MinValue);
        send_request(osm_pkg::CMD_KTH, Capacity);
        send_request(osm_pkg::CMD_KTH, Capacity + 1);
        send_request(osm_pkg::CMD_RANK, MaxValue);
        send_request(osm_pkg::CMD_PRED, MaxValue);
        send_request(osm_pkg::CMD_SUCC, MinValue);
        while (multiset_q.size() > Capacity / 4) begin
            send_request(osm_pkg::CMD_ERASE,
                         multiset_q[$urandom_range(0, multiset_q.size() - 1)]);
        end
        wait_until_drained();
    endtask

    // Requests and results with no idling at all, so every request sees the
    // store as the one just before it left it.
    task automatic test_back_to_back();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        repeat (350) send_random_request();
        wait_until_drained();
    endtask

    // The receiver holds off for a long stretch while requests keep coming, so
    // the unit must stall its input without losing or repeating a request.
    task automatic test_output_stall();
        src_idle_en      = 1'b0;
        sink_idle_en     = 1'b1;
        sink_hold_cycles = LongHoldCycles;
        repeat (40) send_random_request();
        wait_until_drained();
    endtask

    // The bulk of the run: random gaps on both sides, with the sender pausing
    // now and then until every answer is back.
    task automatic test_random_with_idling();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        for (int i = 0; i < 1100; i++) begin
            send_random_request();
            if (i % 200 == 199) wait_until_drained();
        end
        wait_until_drained();
    endtask

    // ------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------

    initial begin : stimulus
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_fill_to_capacity();
        test_back_to_back();
        test_output_stall();
        test_random_with_idling();

        wait_until_drained();
        repeat (SettleCycles) @(posedge i_clk);

        $display("Checked %0d answers: insert %0d, erase %0d, rank %0d, k-th %0d, %s",
                 results_checked, requests_by_cmd[osm_pkg::CMD_INSERT],
                 requests_by_cmd[osm_pkg::CMD_ERASE], requests_by_cmd[osm_pkg::CMD_RANK],
                 requests_by_cmd[osm_pkg::CMD_KTH],
                 $sformatf("pred %0d, succ %0d.", requests_by_cmd[osm_pkg::CMD_PRED],
                           requests_by_cmd[osm_pkg::CMD_SUCC]));
        $display("Store reached %0d of %0d entries; %0d full rejections, %0d not-found answers.",
                 peak_size, Capacity, full_rejections, not_found_answers);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
